### rtl/hvsp_pkg.sv
// Shared types, constants and the frame table of the serial program sequencer.
// Depends on nothing; every other file of the block imports it.
package hvsp_pkg;

    typedef enum logic [3:0] {
        OP_LOAD_ADDR = 4'd0,
        OP_ERASE     = 4'd1,
        OP_WR_FLASH  = 4'd2,
        OP_WR_EEPROM = 4'd3,
        OP_RD_FLASH  = 4'd4,
        OP_RD_EEPROM = 4'd5,
        OP_WR_FUSE   = 4'd6,
        OP_WR_LOCK   = 4'd7,
        OP_RD_FUSE   = 4'd8,
        OP_RD_LOCK   = 4'd9,
        OP_RD_SIG    = 4'd10,
        OP_RD_CAL    = 4'd11
    } opcode_t;

    typedef enum logic [2:0] {
        K_SHIFT   = 3'd0,
        K_CAPTURE = 3'd1,
        K_POLL    = 3'd2,
        K_DELAY   = 3'd3,
        K_FAIL    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        CL_WF_PAGE,
        CL_WE_PAGE,
        CL_WF_BYTE,
        CL_WE_BYTE,
        CL_RD_FLASH,
        CL_RD_EEPROM,
        CL_ERASE,
        CL_WR_FUSE,
        CL_RD_FUSE,
        CL_RD_SIG,
        CL_FAIL
    } class_t;

    typedef enum logic [1:0] {
        REG_PROGRAM_MODE = 2'd0,
        REG_POLL_TIMEOUT = 2'd1,
        REG_ERASE_TIME   = 2'd2
    } cfg_reg_t;

    // Control byte codes: XA1,XA0,BS1,nWR,nOE,BS2,PAGEL from bit 6 down to bit 0.
    localparam logic [6:0] CTL_CMD     = 7'h4C;
    localparam logic [6:0] CTL_ALO     = 7'h0C;
    localparam logic [6:0] CTL_AHI     = 7'h1C;
    localparam logic [6:0] CTL_DLO     = 7'h2C;
    localparam logic [6:0] CTL_DHI     = 7'h3C;
    localparam logic [6:0] CTL_PGL_LO  = 7'h6D;
    localparam logic [6:0] CTL_PGL_HI  = 7'h7D;
    localparam logic [6:0] CTL_IDLE    = 7'h6C;
    localparam logic [6:0] CTL_IDLE_HI = 7'h7C;
    localparam logic [6:0] CTL_WR      = 7'h64;
    localparam logic [6:0] CTL_WR_HI   = 7'h74;
    localparam logic [6:0] CTL_RD      = 7'h68;
    localparam logic [6:0] CTL_RD_HI   = 7'h78;

    localparam logic [6:0] SEL_LOW  = 7'h00;
    localparam logic [6:0] SEL_HIGH = 7'h10;
    localparam logic [6:0] SEL_EXT  = 7'h02;
    localparam logic [6:0] SEL_EXT2 = 7'h12;

    localparam logic [7:0] CMD_CHIP_ERASE = 8'h80;
    localparam logic [7:0] CMD_WR_FUSE    = 8'h40;
    localparam logic [7:0] CMD_WR_LOCK    = 8'h20;
    localparam logic [7:0] CMD_WR_FLASH   = 8'h10;
    localparam logic [7:0] CMD_WR_EEPROM  = 8'h11;
    localparam logic [7:0] CMD_RD_SIGCAL  = 8'h08;
    localparam logic [7:0] CMD_RD_FUSELCK = 8'h04;
    localparam logic [7:0] CMD_RD_FLASH   = 8'h02;
    localparam logic [7:0] CMD_RD_EEPROM  = 8'h03;
    localparam logic [7:0] CMD_NOP        = 8'h00;

    localparam int MODE_PAGE_BIT   = 0;
    localparam int MODE_LAST_BIT   = 6;
    localparam int MODE_COMMIT_BIT = 7;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [15:0] address;
        logic [7:0]  data_low;
        logic [7:0]  data_high;
        logic [1:0]  fuse_index;
        logic        first;
        logic        last;
    } req_t;

    typedef struct packed {
        logic [6:0] control_byte;
        logic [7:0] data_byte;
        logic [2:0] frame_kind;
        logic       last_frame;
    } rsp_t;

    typedef struct packed {
        class_t     cls;
        logic [6:0] sel;
        logic [7:0] cmd;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] alo;
        logic [7:0] ahi;
        logic       skip;
        logic       has_nop;
        logic       use_delay;
        logic [3:0] count;
    } desc_t;

    typedef struct packed {
        logic [6:0] ctl;
        logic [7:0] data;
        kind_t      kind;
    } frame_t;

    function automatic frame_t mk(logic [6:0] ctl, logic [7:0] data, kind_t kind);
        frame_t f;
        f.ctl  = ctl;
        f.data = data;
        f.kind = kind;
        return f;
    endfunction

    // Frame number k of a request, counted as if the command frame were present.
    function automatic frame_t frame_at(desc_t d, logic [3:0] k);
        frame_t f;
        f = mk(7'h00, 8'h00, K_SHIFT);
        unique case (d.cls)
            CL_WF_PAGE, CL_WE_PAGE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_ALO, d.alo, K_SHIFT);
                    4'd2: f = mk(CTL_DLO, d.lo, K_SHIFT);
                    4'd3: f = (d.cls == CL_WF_PAGE) ? mk(CTL_DHI, d.hi, K_SHIFT)
                                                    : mk(CTL_PGL_LO, 8'h00, K_SHIFT);
                    4'd4: f = (d.cls == CL_WF_PAGE) ? mk(CTL_PGL_HI, 8'h00, K_SHIFT)
                                                    : mk(CTL_IDLE, 8'h00, K_SHIFT);
                    4'd5: f = (d.cls == CL_WF_PAGE) ? mk(CTL_IDLE_HI, 8'h00, K_SHIFT)
                                                    : mk(CTL_AHI, d.ahi, K_SHIFT);
                    4'd6: f = (d.cls == CL_WF_PAGE) ? mk(CTL_AHI, d.ahi, K_SHIFT)
                                                    : mk(CTL_WR, 8'h00, K_SHIFT);
                    4'd7: f = (d.cls == CL_WF_PAGE) ? mk(CTL_WR, 8'h00, K_SHIFT)
                                                    : mk(CTL_IDLE, 8'h00, K_SHIFT);
                    4'd8: f = (d.cls == CL_WF_PAGE) ? mk(CTL_IDLE, 8'h00, K_SHIFT)
                                                    : mk(7'h00, 8'h00, K_POLL);
                    default: f = mk(7'h00, 8'h00, K_POLL);
                endcase
            end
            CL_WF_BYTE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_ALO, d.alo, K_SHIFT);
                    4'd2: f = mk(CTL_AHI, d.ahi, K_SHIFT);
                    4'd3: f = mk(CTL_DLO, d.lo, K_SHIFT);
                    4'd4: f = mk(CTL_WR, 8'h00, K_SHIFT);
                    4'd5: f = mk(CTL_IDLE, 8'h00, K_SHIFT);
                    4'd7: f = mk(CTL_DHI, d.hi, K_SHIFT);
                    4'd8: f = mk(CTL_WR_HI, 8'h00, K_SHIFT);
                    4'd9: f = mk(CTL_IDLE_HI, 8'h00, K_SHIFT);
                    default: f = mk(7'h00, 8'h00, K_POLL);
                endcase
            end
            CL_WE_BYTE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_ALO, d.alo, K_SHIFT);
                    4'd2: f = mk(CTL_AHI, d.ahi, K_SHIFT);
                    4'd3: f = mk(CTL_DLO, d.lo, K_SHIFT);
                    4'd4: f = mk(CTL_PGL_LO, 8'h00, K_SHIFT);
                    4'd5: f = mk(CTL_WR, 8'h00, K_SHIFT);
                    4'd6: f = mk(CTL_IDLE, 8'h00, K_SHIFT);
                    default: f = mk(7'h00, 8'h00, K_POLL);
                endcase
            end
            CL_RD_FLASH, CL_RD_EEPROM:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_ALO, d.alo, K_SHIFT);
                    4'd2: f = mk(CTL_AHI, d.ahi, K_SHIFT);
                    4'd3: f = mk(CTL_RD, 8'h00, K_SHIFT);
                    4'd4: f = mk(CTL_IDLE, 8'h00, K_CAPTURE);
                    4'd5: f = mk(CTL_RD_HI, 8'h00, K_SHIFT);
                    default: f = mk(CTL_IDLE_HI, 8'h00, K_CAPTURE);
                endcase
            end
            CL_ERASE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_WR, 8'h00, K_SHIFT);
                    4'd2: f = mk(CTL_IDLE, 8'h00, K_SHIFT);
                    default: f = d.use_delay ? mk(7'h00, d.hi, K_DELAY)
                                             : mk(7'h00, 8'h00, K_POLL);
                endcase
            end
            CL_WR_FUSE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_DLO, d.lo, K_SHIFT);
                    4'd2: f = mk(CTL_WR | d.sel, 8'h00, K_SHIFT);
                    4'd3: f = mk(CTL_IDLE | d.sel, 8'h00, K_SHIFT);
                    default: f = mk(7'h00, 8'h00, K_POLL);
                endcase
            end
            CL_RD_FUSE:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_RD | d.sel, 8'h00, K_SHIFT);
                    default: f = mk(CTL_IDLE | d.sel, 8'h00, K_CAPTURE);
                endcase
            end
            CL_RD_SIG:
            begin
                unique case (k)
                    4'd0: f = mk(CTL_CMD, d.cmd, K_SHIFT);
                    4'd1: f = mk(CTL_ALO, d.alo, K_SHIFT);
                    4'd2: f = mk(CTL_RD | d.sel, 8'h00, K_SHIFT);
                    default: f = mk(CTL_IDLE | d.sel, 8'h00, K_CAPTURE);
                endcase
            end
            default: f = mk(7'h00, 8'h00, K_FAIL);
        endcase
        return f;
    endfunction

endpackage

### rtl/hvsp_front.sv
// Request decoder: holds the configuration registers and the word address,
// and turns each accepted request other than a load address into a frame descriptor. Uses hvsp_pkg.
module hvsp_front
    import hvsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  req_t       req,
    input  logic       q_full,
    output logic       full,
    output logic       q_push,
    output desc_t      q_desc,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]  program_mode_reg;
    logic [7:0]  poll_timeout_reg;
    logic [7:0]  erase_time_reg;
    logic [15:0] word_address_reg;
    logic [15:0] word_address_next;

    logic        accept;
    logic        page;
    logic        nop_close;
    logic [2:0]  shamt;
    logic [7:0]  mask;
    logic [7:0]  alo_inc;
    logic        commit;
    logic [3:0]  first_adj;
    logic [3:0]  nop_add;
    desc_t       d;

    assign full      = q_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;

    assign page      = program_mode_reg[MODE_PAGE_BIT];
    assign nop_close = req.last && (!page || program_mode_reg[MODE_LAST_BIT]);
    assign shamt     = 3'(4'd8 - {1'b0, program_mode_reg[3:1]});
    assign alo_inc   = word_address_reg[7:0] + 8'd1;
    assign first_adj = {3'b000, !req.first};
    assign nop_add   = {3'b000, nop_close};

    always_comb
    begin
        mask = 8'hFF >> shamt;
        if (opcode_t'(req.opcode) == OP_WR_FLASH)
        begin
            mask = mask >> 1;
        end
        commit = ((alo_inc & mask) == 8'h00) && program_mode_reg[MODE_COMMIT_BIT];
    end

    always_comb
    begin
        d           = '0;
        d.cls       = CL_FAIL;
        d.count     = 4'd1;
        d.alo       = word_address_reg[7:0];
        d.ahi       = word_address_reg[15:8];
        d.lo        = req.data_low;
        d.hi        = req.data_high;
        d.sel       = SEL_LOW;
        d.use_delay = (poll_timeout_reg == 8'h00);
        q_push      = accept;
        word_address_next = word_address_reg;
        unique case (opcode_t'(req.opcode))
            OP_LOAD_ADDR:
            begin
                q_push = 1'b0;
                if (accept)
                begin
                    word_address_next = req.address;
                end
            end
            OP_ERASE:
            begin
                d.cls     = CL_ERASE;
                d.cmd     = CMD_CHIP_ERASE;
                d.hi      = erase_time_reg;
                d.has_nop = 1'b1;
                d.count   = 4'd5;
            end
            OP_WR_FLASH, OP_WR_EEPROM:
            begin
                d.skip    = !req.first;
                d.has_nop = nop_close;
                if (opcode_t'(req.opcode) == OP_WR_FLASH)
                begin
                    d.cmd = CMD_WR_FLASH;
                    if (page)
                    begin
                        d.cls   = CL_WF_PAGE;
                        d.count = 4'd6 + (commit ? 4'd4 : 4'd0) + nop_add - first_adj;
                    end
                    else
                    begin
                        d.cls   = CL_WF_BYTE;
                        d.count = 4'd11 + nop_add - first_adj;
                    end
                end
                else
                begin
                    d.cmd = CMD_WR_EEPROM;
                    d.hi  = 8'h00;
                    if (page)
                    begin
                        d.cls   = CL_WE_PAGE;
                        d.count = 4'd5 + (commit ? 4'd4 : 4'd0) + nop_add - first_adj;
                    end
                    else
                    begin
                        d.cls   = CL_WE_BYTE;
                        d.count = 4'd8 + nop_add - first_adj;
                    end
                end
                if (accept)
                begin
                    word_address_next = word_address_reg + 16'd1;
                end
            end
            OP_RD_FLASH:
            begin
                d.cls   = CL_RD_FLASH;
                d.cmd   = CMD_RD_FLASH;
                d.skip  = !req.first;
                d.count = 4'd7 - first_adj;
                if (accept)
                begin
                    word_address_next = word_address_reg + 16'd1;
                end
            end
            OP_RD_EEPROM:
            begin
                d.cls   = CL_RD_EEPROM;
                d.cmd   = CMD_RD_EEPROM;
                d.skip  = !req.first;
                d.count = 4'd5 - first_adj;
                if (accept)
                begin
                    word_address_next = word_address_reg + 16'd1;
                end
            end
            OP_WR_FUSE, OP_WR_LOCK:
            begin
                d.cls     = CL_WR_FUSE;
                d.has_nop = 1'b1;
                d.count   = 4'd6;
                if (opcode_t'(req.opcode) == OP_WR_FUSE)
                begin
                    d.cmd = CMD_WR_FUSE;
                    unique case (req.fuse_index)
                        2'd0:    d.sel = SEL_LOW;
                        2'd1:    d.sel = SEL_HIGH;
                        default: d.sel = SEL_EXT;
                    endcase
                end
                else
                begin
                    d.cmd = CMD_WR_LOCK;
                end
            end
            OP_RD_FUSE, OP_RD_LOCK:
            begin
                d.cls   = CL_RD_FUSE;
                d.cmd   = CMD_RD_FUSELCK;
                d.count = 4'd3;
                if (opcode_t'(req.opcode) == OP_RD_LOCK)
                begin
                    d.sel = SEL_HIGH;
                end
                else
                begin
                    unique case (req.fuse_index)
                        2'd0: d.sel = SEL_LOW;
                        2'd1: d.sel = SEL_EXT2;
                        2'd2: d.sel = SEL_EXT;
                        default:
                        begin
                            d.cls   = CL_FAIL;
                            d.count = 4'd1;
                        end
                    endcase
                end
            end
            OP_RD_SIG, OP_RD_CAL:
            begin
                d.cls   = CL_RD_SIG;
                d.cmd   = CMD_RD_SIGCAL;
                d.count = 4'd4;
                if (opcode_t'(req.opcode) == OP_RD_SIG)
                begin
                    d.alo = req.address[7:0];
                end
                else
                begin
                    d.alo = 8'h00;
                    d.sel = SEL_HIGH;
                end
            end
            default:
            begin
                d.cls   = CL_FAIL;
                d.count = 4'd1;
            end
        endcase
    end

    assign q_desc = d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_mode_reg <= 8'h00;
            poll_timeout_reg <= 8'h00;
            erase_time_reg   <= 8'd10;
            word_address_reg <= 16'h0000;
        end
        else
        begin
            word_address_reg <= word_address_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PROGRAM_MODE: program_mode_reg <= cfg_data;
                    REG_POLL_TIMEOUT: poll_timeout_reg <= cfg_data;
                    REG_ERASE_TIME:   erase_time_reg   <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

endmodule

### rtl/hvsp_queue.sv
// Two-entry descriptor queue between the request decoder and the frame emitter.
// Uses hvsp_pkg for the descriptor type.
module hvsp_queue
    import hvsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  wr_en,
    input  desc_t wr_desc,
    output logic  full,
    output logic  valid,
    output desc_t rd_desc,
    input  logic  rd_en
);

    desc_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_desc = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

### rtl/hvsp_back.sv
// Frame emitter: steps through a descriptor one frame a cycle, while the result queue has room, into a two-entry
// result queue. Uses hvsp_pkg for the descriptor, frame table and result type.
module hvsp_back
    import hvsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  q_valid,
    input  desc_t q_desc,
    output logic  q_pop,
    output logic  empty,
    output rsp_t  rsp,
    input  logic  pop
);

    logic [3:0] step_reg;
    logic [3:0] step_next;
    rsp_t       out_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] ocnt_reg;
    logic [1:0] ocnt_next;

    logic       gen_fire;
    logic       last_step;
    logic       do_pop;
    logic [3:0] k;
    frame_t     f;
    rsp_t       r;

    assign gen_fire  = q_valid && (ocnt_reg != 2'd2);
    assign last_step = (step_reg == q_desc.count - 4'd1);
    assign q_pop     = gen_fire && last_step;
    assign do_pop    = pop && (ocnt_reg != 2'd0);
    assign k         = step_reg + {3'b000, q_desc.skip};
    assign empty     = (ocnt_reg == 2'd0);
    assign rsp       = out_reg[rd_ptr_reg];

    always_comb
    begin
        if (q_desc.has_nop && last_step)
        begin
            f = mk(CTL_CMD, CMD_NOP, K_SHIFT);
        end
        else
        begin
            f = frame_at(q_desc, k);
        end
        r.control_byte = f.ctl;
        r.data_byte    = f.data;
        r.frame_kind   = f.kind;
        r.last_frame   = last_step;
    end

    always_comb
    begin
        step_next = step_reg;
        if (gen_fire)
        begin
            step_next = last_step ? 4'd0 : step_reg + 4'd1;
        end
        ocnt_next = ocnt_reg;
        if (gen_fire && !do_pop)
        begin
            ocnt_next = ocnt_reg + 2'd1;
        end
        else if (do_pop && !gen_fire)
        begin
            ocnt_next = ocnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_fire)
        begin
            out_reg[wr_ptr_reg] <= r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 4'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            ocnt_reg   <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
            ocnt_reg <= ocnt_next;
            if (gen_fire)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> (step_reg < q_desc.count))
        else $error("Frame step has run past the descriptor's frame count.");

    a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= 2'd2)
        else $error("Result queue count exceeds its depth.");

    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (step_reg == 4'd0))
        else $error("Frame step did not restart after the last frame of a request.");

    a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (gen_fire && last_step) |-> r.last_frame)
        else $error("Final frame of a request is not marked as last.");

endmodule

### rtl/hv_serial_program_sequencer_core.sv
// Top level of the serial program sequencer: decoder, descriptor queue and
// frame emitter. Uses hvsp_pkg, hvsp_front, hvsp_queue and hvsp_back.
//
//   channel   handshake             payload
//   request   push / full           req (req_t)
//   frames    pop / empty           rsp (rsp_t)
//   config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// A request is decoded into the descriptor queue; the emitter then sends one frame
// per cycle while the result queue has room, and so sets the rate. A load address
// request emits no frames and only updates the word address. Reset empties the
// queues, zeroes the word address and presets the registers; no clearing pass. A
// full result queue stalls the emitter, and a full descriptor queue raises full.
module hv_serial_program_sequencer_core
    import hvsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  req_t       req,
    output logic       empty,
    input  logic       pop,
    output rsp_t       rsp,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic  q_full;
    logic  q_push;
    desc_t q_wr_desc;
    logic  q_valid;
    desc_t q_rd_desc;
    logic  q_pop;

    hvsp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .q_full    (q_full),
        .full      (full),
        .q_push    (q_push),
        .q_desc    (q_wr_desc),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hvsp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_desc (q_wr_desc),
        .full    (q_full),
        .valid   (q_valid),
        .rd_desc (q_rd_desc),
        .rd_en   (q_pop)
    );

    hvsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_desc  (q_rd_desc),
        .q_pop   (q_pop),
        .empty   (empty),
        .rsp     (rsp),
        .pop     (pop)
    );

endmodule

### tb/sv/hv_serial_program_sequencer_core_tb.sv
// Self-checking testbench of the serial program sequencer: directed and random requests,
// every result checked against a frame predictor kept in this file or a typed frame table.
// Depends on hvsp_pkg and hv_serial_program_sequencer_core.
module hv_serial_program_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hvsp_pkg::*;

    localparam logic [6:0] C_PAGEL = 7'h01;
    localparam logic [6:0] C_BS2   = 7'h02;
    localparam logic [6:0] C_NOE   = 7'h04;
    localparam logic [6:0] C_NWR   = 7'h08;
    localparam logic [6:0] C_BS1   = 7'h10;
    localparam logic [6:0] C_XA0   = 7'h20;
    localparam logic [6:0] C_XA1   = 7'h40;

    localparam logic [6:0] A_ADDR  = 7'h00;
    localparam logic [6:0] A_DATA  = C_XA0;
    localparam logic [6:0] A_CMD   = C_XA1;
    localparam logic [6:0] A_NONE  = C_XA1 | C_XA0;
    localparam logic [6:0] A_PGL   = C_XA1 | C_XA0 | C_PAGEL;
    localparam logic [6:0] B_LOW   = 7'h00;
    localparam logic [6:0] B_HIGH  = C_BS1;
    localparam logic [6:0] B_EXT   = C_BS2;
    localparam logic [6:0] B_EXT2  = C_BS1 | C_BS2;
    localparam logic [6:0] M_READ  = C_NWR;
    localparam logic [6:0] M_WRITE = C_NOE;
    localparam logic [6:0] M_NORW  = C_NWR | C_NOE;

    localparam logic [3:0] OP_BAD_FIRST = 4'd12;
    localparam logic [3:0] OP_BAD_LAST  = 4'd15;
    localparam logic [1:0] FUSE_BAD     = 2'd3;

    typedef struct {
        req_t        r;
        int unsigned n_typed;
    } step_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    req_t       req;
    logic       empty;
    logic       pop;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    logic [7:0]  mode_reg = 8'h00;
    logic [7:0]  poll_reg = 8'h00;
    logic [7:0]  erase_reg = 8'd10;
    logic [15:0] word_addr = 16'h0000;

    rsp_t        scratch [$];
    rsp_t        frames_due [$];
    rsp_t        typed_frames [11];
    rsp_t        due;
    step_row_t   directed [25];
    int unsigned typed_n = 0;
    int unsigned typed_off = 0;
    int unsigned send_pct = 0;
    int unsigned recv_pct = 0;
    int unsigned errors = 0;
    int unsigned n_requests = 0;
    int unsigned n_frames = 0;
    int unsigned n_settings = 1;

    hv_serial_program_sequencer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("%0t ns: timeout with %0d frames outstanding", $time, frames_due.size());
        $display("hv_serial_program_sequencer_core: mismatch");
        $finish;
    end

    function automatic void add_frame(logic [6:0] ctl, logic [7:0] data, kind_t kind);
        rsp_t f;
        if (scratch.size() < 12)
        begin
            f.control_byte = ctl;
            f.data_byte    = data;
            f.frame_kind   = kind;
            f.last_frame   = 1'b0;
            scratch.push_back(f);
        end
    endfunction

    function automatic void seq_write(bit eeprom, logic [7:0] lo, logic [7:0] hi,
                                      bit first, bit last);
        logic [7:0] alo;
        logic [7:0] ahi;
        logic [7:0] mask;
        logic [7:0] nxt;
        logic [2:0] sh;
        alo = word_addr[7:0];
        ahi = word_addr[15:8];
        if (first)
            add_frame(A_CMD | B_LOW | M_NORW, eeprom ? CMD_WR_EEPROM : CMD_WR_FLASH, K_SHIFT);
        add_frame(A_ADDR | B_LOW | M_NORW, alo, K_SHIFT);
        if (mode_reg[MODE_PAGE_BIT])
        begin
            sh = 3'd0 - mode_reg[3:1];
            mask = 8'hFF >> sh;
            if (!eeprom)
                mask = mask >> 1;
            add_frame(A_DATA | B_LOW | M_NORW, lo, K_SHIFT);
            if (eeprom)
            begin
                add_frame(A_PGL | B_LOW | M_NORW, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_SHIFT);
            end
            else
            begin
                add_frame(A_DATA | B_HIGH | M_NORW, hi, K_SHIFT);
                add_frame(A_PGL | B_HIGH | M_NORW, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_HIGH | M_NORW, 8'h00, K_SHIFT);
            end
            nxt = alo + 8'd1;
            if (((nxt & mask) == 8'h00) && mode_reg[MODE_COMMIT_BIT])
            begin
                add_frame(A_ADDR | B_HIGH | M_NORW, ahi, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_WRITE, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_SHIFT);
                add_frame(7'h00, 8'h00, K_POLL);
            end
        end
        else
        begin
            add_frame(A_ADDR | B_HIGH | M_NORW, ahi, K_SHIFT);
            add_frame(A_DATA | B_LOW | M_NORW, lo, K_SHIFT);
            if (eeprom)
            begin
                add_frame(A_PGL | B_LOW | M_NORW, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_WRITE, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_SHIFT);
            end
            else
            begin
                add_frame(A_NONE | B_LOW | M_WRITE, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_SHIFT);
                add_frame(7'h00, 8'h00, K_POLL);
                add_frame(A_DATA | B_HIGH | M_NORW, hi, K_SHIFT);
                add_frame(A_NONE | B_HIGH | M_WRITE, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_HIGH | M_NORW, 8'h00, K_SHIFT);
            end
            add_frame(7'h00, 8'h00, K_POLL);
        end
        word_addr = word_addr + 16'd1;
        if (last && (!mode_reg[MODE_PAGE_BIT] || mode_reg[MODE_LAST_BIT]))
            add_frame(A_CMD | B_LOW | M_NORW, CMD_NOP, K_SHIFT);
    endfunction

    function automatic void seq_read(bit eeprom, bit first);
        if (first)
            add_frame(A_CMD | B_LOW | M_NORW, eeprom ? CMD_RD_EEPROM : CMD_RD_FLASH, K_SHIFT);
        add_frame(A_ADDR | B_LOW | M_NORW, word_addr[7:0], K_SHIFT);
        add_frame(A_ADDR | B_HIGH | M_NORW, word_addr[15:8], K_SHIFT);
        add_frame(A_NONE | B_LOW | M_READ, 8'h00, K_SHIFT);
        add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_CAPTURE);
        if (!eeprom)
        begin
            add_frame(A_NONE | B_HIGH | M_READ, 8'h00, K_SHIFT);
            add_frame(A_NONE | B_HIGH | M_NORW, 8'h00, K_CAPTURE);
        end
        word_addr = word_addr + 16'd1;
    endfunction

    function automatic void seq_fuse_write(logic [7:0] value, logic [7:0] cmd,
                                           logic [6:0] sel);
        add_frame(A_CMD | B_LOW | M_NORW, cmd, K_SHIFT);
        add_frame(A_DATA | B_LOW | M_NORW, value, K_SHIFT);
        add_frame(A_NONE | sel | M_WRITE, 8'h00, K_SHIFT);
        add_frame(A_NONE | sel | M_NORW, 8'h00, K_SHIFT);
        add_frame(7'h00, 8'h00, K_POLL);
        add_frame(A_CMD | B_LOW | M_NORW, CMD_NOP, K_SHIFT);
    endfunction

    function automatic void seq_fuse_read(logic [6:0] sel);
        add_frame(A_CMD | B_LOW | M_NORW, CMD_RD_FUSELCK, K_SHIFT);
        add_frame(A_NONE | sel | M_READ, 8'h00, K_SHIFT);
        add_frame(A_NONE | sel | M_NORW, 8'h00, K_CAPTURE);
    endfunction

    function automatic void seq_sig(logic [7:0] addr, logic [6:0] sel);
        add_frame(A_CMD | B_LOW | M_NORW, CMD_RD_SIGCAL, K_SHIFT);
        add_frame(A_ADDR | B_LOW | M_NORW, addr, K_SHIFT);
        add_frame(A_NONE | sel | M_READ, 8'h00, K_SHIFT);
        add_frame(A_NONE | sel | M_NORW, 8'h00, K_CAPTURE);
    endfunction

    function automatic void predict_frames(req_t r);
        scratch.delete();
        case (r.opcode)
            OP_LOAD_ADDR: word_addr = r.address;
            OP_ERASE:
            begin
                add_frame(A_CMD | B_LOW | M_NORW, CMD_CHIP_ERASE, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_WRITE, 8'h00, K_SHIFT);
                add_frame(A_NONE | B_LOW | M_NORW, 8'h00, K_SHIFT);
                if (poll_reg != 8'h00)
                    add_frame(7'h00, 8'h00, K_POLL);
                else
                    add_frame(7'h00, erase_reg, K_DELAY);
                add_frame(A_CMD | B_LOW | M_NORW, CMD_NOP, K_SHIFT);
            end
            OP_WR_FLASH:  seq_write(1'b0, r.data_low, r.data_high, r.first, r.last);
            OP_WR_EEPROM: seq_write(1'b1, r.data_low, 8'h00, r.first, r.last);
            OP_RD_FLASH:  seq_read(1'b0, r.first);
            OP_RD_EEPROM: seq_read(1'b1, r.first);
            OP_WR_FUSE:
                seq_fuse_write(r.data_low, CMD_WR_FUSE,
                               r.fuse_index == 2'd0 ? B_LOW :
                               (r.fuse_index == 2'd1 ? B_HIGH : B_EXT));
            OP_WR_LOCK:   seq_fuse_write(r.data_low, CMD_WR_LOCK, B_LOW);
            OP_RD_FUSE:
            begin
                if (r.fuse_index == 2'd0)
                    seq_fuse_read(B_LOW);
                else if (r.fuse_index == 2'd1)
                    seq_fuse_read(B_EXT2);
                else if (r.fuse_index == 2'd2)
                    seq_fuse_read(B_EXT);
                else
                    add_frame(7'h00, 8'h00, K_FAIL);
            end
            OP_RD_LOCK:   seq_fuse_read(B_HIGH);
            OP_RD_SIG:    seq_sig(r.address[7:0], B_LOW);
            OP_RD_CAL:    seq_sig(8'h00, B_HIGH);
            default:      add_frame(7'h00, 8'h00, K_FAIL);
        endcase
        if (scratch.size() > 0)
            scratch[scratch.size() - 1].last_frame = 1'b1;
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && push && !full)
        begin
            predict_frames(req);
            if (typed_n > 0)
            begin
                for (int i = 0; i < typed_n; i++)
                    frames_due.push_back(typed_frames[typed_off + i]);
            end
            else
            begin
                foreach (scratch[i])
                    frames_due.push_back(scratch[i]);
            end
            n_requests++;
        end
        if (rst_n && pop && !empty)
        begin
            n_frames++;
            if (frames_due.size() == 0)
            begin
                errors++;
                $display("%0t ns: frame %0h with nothing expected", $time, rsp);
            end
            else
            begin
                due = frames_due.pop_front();
                check_field("control_byte", 8'(due.control_byte), 8'(rsp.control_byte));
                check_field("data_byte", due.data_byte, rsp.data_byte);
                check_field("frame_kind", 8'(due.frame_kind), 8'(rsp.frame_kind));
                check_field("last_frame", 8'(due.last_frame), 8'(rsp.last_frame));
            end
        end
    end

    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop <= (recv_pct == 0) || ($urandom_range(0, 99) >= recv_pct);
        end
    end

    function automatic req_t mkreq(logic [3:0] op, logic [15:0] addr, logic [7:0] lo,
                                   logic [7:0] hi, logic [1:0] fidx, bit first, bit last);
        req_t r;
        r.opcode     = op;
        r.address    = addr;
        r.data_low   = lo;
        r.data_high  = hi;
        r.fuse_index = fidx;
        r.first      = first;
        r.last       = last;
        return r;
    endfunction

    function automatic req_t rand_req(logic [3:0] op);
        return mkreq(op, 16'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
                     1'($urandom), 1'($urandom));
    endfunction

    task automatic send(input req_t r, input int unsigned n_typ = 0,
                        input int unsigned off = 0);
        @(negedge clk);
        while ((send_pct != 0) && ($urandom_range(0, 99) < send_pct))
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        typed_n = n_typ;
        typed_off = off;
        push <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
        @(negedge clk);
        push <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PROGRAM_MODE: mode_reg = value;
            REG_POLL_TIMEOUT: poll_reg = value;
            REG_ERASE_TIME:   erase_reg = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int unsigned n_items);
        int unsigned done;
        int unsigned pick;
        int unsigned len;
        bit          ee;
        req_t        r;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                r = rand_req(OP_LOAD_ADDR);
                if ($urandom_range(0, 1) == 1)
                    r.address[7:0] = 8'hFF - 8'($urandom_range(0, 5));
                send(r);
                ee = 1'($urandom);
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    r = rand_req(ee ? OP_WR_EEPROM : OP_WR_FLASH);
                    r.first = (k == 0);
                    r.last = (k == len - 1);
                    send(r);
                    done++;
                end
            end
            else if (pick < 65)
            begin
                send(rand_req(OP_LOAD_ADDR));
                ee = 1'($urandom);
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++)
                begin
                    r = rand_req(ee ? OP_RD_EEPROM : OP_RD_FLASH);
                    r.first = (k == 0);
                    send(r);
                    done++;
                end
            end
            else if (pick < 80)
            begin
                case ($urandom_range(0, 5))
                    0: r = rand_req(OP_WR_FUSE);
                    1: r = rand_req(OP_WR_LOCK);
                    2: r = rand_req(OP_RD_FUSE);
                    3: r = rand_req(OP_RD_LOCK);
                    4: r = rand_req(OP_RD_SIG);
                    default: r = rand_req(OP_RD_CAL);
                endcase
                send(r);
                done++;
            end
            else if (pick < 86)
            begin
                send(rand_req(OP_ERASE));
                done++;
            end
            else
            begin
                send(rand_req(4'($urandom_range(0, 15))));
                done++;
            end
        end
    endtask

    initial
    begin
        int unsigned off;
        rst_n = 1'b0;
        push = 1'b0;
        req = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_PROGRAM_MODE;
        cfg_data = 8'h00;

        typed_frames = '{
            '{A_CMD | M_NORW, CMD_CHIP_ERASE, K_SHIFT, 1'b0},
            '{A_NONE | M_WRITE, 8'h00, K_SHIFT, 1'b0},
            '{A_NONE | M_NORW, 8'h00, K_SHIFT, 1'b0},
            '{7'h00, 8'd10, K_DELAY, 1'b0},
            '{A_CMD | M_NORW, CMD_NOP, K_SHIFT, 1'b1},
            '{A_CMD | M_NORW, CMD_RD_FUSELCK, K_SHIFT, 1'b0},
            '{A_NONE | B_HIGH | M_READ, 8'h00, K_SHIFT, 1'b0},
            '{A_NONE | B_HIGH | M_NORW, 8'h00, K_CAPTURE, 1'b1},
            '{7'h00, 8'h00, K_FAIL, 1'b1},
            '{7'h00, 8'h00, K_FAIL, 1'b1},
            '{7'h00, 8'h00, K_FAIL, 1'b1}
        };

        directed = '{
            '{mkreq(OP_ERASE, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 5},
            '{mkreq(OP_RD_LOCK, 16'hFFFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 1'b1), 3},
            '{mkreq(OP_BAD_FIRST, 16'hFFFF, 8'hFF, 8'hFF, 2'd3, 1'b1, 1'b1), 1},
            '{mkreq(OP_BAD_LAST, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 1},
            '{mkreq(OP_RD_FUSE, 16'h1234, 8'h00, 8'h00, FUSE_BAD, 1'b0, 1'b0), 1},
            '{mkreq(OP_RD_FUSE, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_FUSE, 16'h0000, 8'h00, 8'h00, 2'd1, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_FUSE, 16'h0000, 8'h00, 8'h00, 2'd2, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_FUSE, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_FUSE, 16'h0000, 8'hFF, 8'h00, 2'd1, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_FUSE, 16'h0000, 8'h5A, 8'h00, 2'd2, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_FUSE, 16'h0000, 8'hA5, 8'h00, FUSE_BAD, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_LOCK, 16'h0000, 8'hFF, 8'hFF, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_SIG, 16'hFFFF, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_SIG, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_CAL, 16'hFFFF, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_LOAD_ADDR, 16'hFFFF, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_WR_FLASH, 16'h0000, 8'hFF, 8'hFF, 2'd0, 1'b1, 1'b1), 0},
            '{mkreq(OP_WR_EEPROM, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1), 0},
            '{mkreq(OP_LOAD_ADDR, 16'hFFFE, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_FLASH, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b1, 1'b0), 0},
            '{mkreq(OP_RD_FLASH, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b0, 1'b0), 0},
            '{mkreq(OP_RD_EEPROM, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b1, 1'b1), 0},
            '{mkreq(OP_WR_FLASH, 16'h0000, 8'h00, 8'h00, 2'd0, 1'b1, 1'b0), 0},
            '{mkreq(OP_WR_FLASH, 16'h0000, 8'hFF, 8'hFF, 2'd0, 1'b0, 1'b1), 0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        off = 0;
        foreach (directed[i])
        begin
            send(directed[i].r, directed[i].n_typed, off);
            off += directed[i].n_typed;
        end

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'hFF);
                    write_reg(REG_POLL_TIMEOUT, 8'hFF);
                    write_reg(REG_ERASE_TIME, 8'hFF);
                end
                1:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'h00);
                    write_reg(REG_POLL_TIMEOUT, 8'h00);
                    write_reg(REG_ERASE_TIME, 8'h00);
                end
                2:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'hC1);
                    write_reg(REG_POLL_TIMEOUT, 8'h01);
                    write_reg(REG_ERASE_TIME, 8'($urandom));
                end
                3:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'($urandom) | 8'h01);
                    write_reg(REG_POLL_TIMEOUT, 8'($urandom));
                    write_reg(REG_ERASE_TIME, 8'($urandom));
                end
                4:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'h8F);
                    write_reg(REG_POLL_TIMEOUT, 8'h00);
                    write_reg(REG_ERASE_TIME, 8'($urandom));
                end
                5:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'($urandom));
                    write_reg(REG_POLL_TIMEOUT, 8'h00);
                    write_reg(REG_ERASE_TIME, 8'hFF);
                end
                default:
                begin
                    write_reg(REG_PROGRAM_MODE, 8'h41 | (8'($urandom) & 8'h0E));
                    write_reg(REG_POLL_TIMEOUT, 8'($urandom));
                    write_reg(REG_ERASE_TIME, 8'($urandom));
                end
            endcase
            n_settings++;
            case (p % 4)
                0: begin send_pct = 0;  recv_pct = 0;  end
                1: begin send_pct = 45; recv_pct = 0;  end
                2: begin send_pct = 0;  recv_pct = 45; end
                default: begin send_pct = 23; recv_pct = 23; end
            endcase
            run_random(45);
        end

        @(negedge clk);
        push <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Covered %0d requests and %0d frames over %0d register settings,",
                 n_requests, n_frames, n_settings);
        $display("with idle-free, sender-idle, receiver-stall and mixed phases.");
        if (frames_due.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d expected frames never arrived", $time, frames_due.size());
        end
        if (errors == 0)
            $display("hv_serial_program_sequencer_core: match");
        else
            $display("hv_serial_program_sequencer_core: mismatch");
        $finish;
    end

endmodule

### files.f
rtl/hvsp_pkg.sv
rtl/hvsp_front.sv
rtl/hvsp_queue.sv
rtl/hvsp_back.sv
rtl/hv_serial_program_sequencer_core.sv
tb/sv/hv_serial_program_sequencer_core_tb.sv
